// ===== src/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int          CSR_ADDR_W     = 3;
   localparam int          CSR_DATA_W     = 32;
   localparam int          REQ_DATA_W     = 8;
   localparam int          RSP_DATA_W     = 56;
   localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
   localparam logic [7:0]  SYNC_BYTE      = 8'hFF;
   localparam logic [8:0]  SUM_MOD        = 9'd255;
   localparam logic [15:0] TIMER_MAX      = 16'hFFFF;

   typedef enum logic [0:0] {
      CSR_TIMEOUT = 1'b0
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD = 2'd0,
      EV_GOOD    = 2'd1,
      EV_BAD     = 2'd2,
      EV_ABORT   = 2'd3
   } evt_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_SYNC2 = 3'd1,
      PH_HEAD  = 3'd2,
      PH_DATA  = 3'd3,
      PH_CSUM  = 3'd4
   } phase_type;

   typedef struct packed {
      logic        valid;
      evt_type     event_res;
      logic [7:0]  sender_id;
      logic [7:0]  receiver_id;
      logic [7:0]  payload_byte;
      logic [15:0] byte_index;
      logic [15:0] frame_length;
      logic        last;
   } rsp_item_type;

endpackage

// ===== src/sfr_csr.sv =====
// ----------------------------------------------------------------------------
// sfr_csr
// Configuration register file: holds the timeout in ticks.
// ----------------------------------------------------------------------------
module sfr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sfr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output logic [15:0]                      timeout_ticks
);
   import sfr_pkg::*;

   logic [15:0]   timeout_ff;
   logic [15:0]   timeout_in;
   csr_index_type reg_index;
   logic          wr_en;

   assign reg_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      timeout_in = timeout_ff;
      if (wr_en && reg_index == CSR_TIMEOUT) begin
         timeout_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (reg_index)
         CSR_TIMEOUT: csr_prdata = {{(CSR_DATA_W-16){1'b0}}, timeout_ff};
         default:     csr_prdata = '0;
      endcase
   end

   assign timeout_ticks = timeout_ff;

endmodule

// ===== src/sfr_parser.sv =====
// ----------------------------------------------------------------------------
// sfr_parser
// Frame parser state: sync detection, header capture, running checksum,
// payload indexing and tick timeout. One transaction per step.
// ----------------------------------------------------------------------------
module sfr_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  opcode,
   input  logic [7:0]            rx_byte,
   input  logic [15:0]           timeout_ticks,
   output sfr_pkg::rsp_item_type result
);
   import sfr_pkg::*;

   phase_type   phase_ff,   phase_in;
   logic [1:0]  hcount_ff,  hcount_in;
   logic [7:0]  sender_ff,  sender_in;
   logic [7:0]  receiver_ff, receiver_in;
   logic [15:0] length_ff,  length_in;
   logic [15:0] pcount_ff,  pcount_in;
   logic [7:0]  sum_ff,     sum_in;
   logic        tactive_ff, tactive_in;
   logic [15:0] tcount_ff,  tcount_in;

   logic [8:0]  sum_raw;
   logic [7:0]  sum_next;
   logic [15:0] tcount_inc;
   logic [15:0] len_hdr;
   logic [15:0] pcount_inc;

   assign sum_raw    = {1'b0, sum_ff} + {1'b0, rx_byte};
   assign sum_next   = (sum_raw >= SUM_MOD) ? 8'(sum_raw - SUM_MOD) : sum_raw[7:0];
   assign tcount_inc = (tcount_ff != TIMER_MAX) ? 16'(tcount_ff + 16'd1) : tcount_ff;
   assign len_hdr    = (hcount_ff == 2'd2) ? {rx_byte, 8'h00} : {length_ff[15:8], rx_byte};
   assign pcount_inc = 16'(pcount_ff + 16'd1);

   always_comb begin
      phase_in    = phase_ff;
      hcount_in   = hcount_ff;
      sender_in   = sender_ff;
      receiver_in = receiver_ff;
      length_in   = length_ff;
      pcount_in   = pcount_ff;
      sum_in      = sum_ff;
      tactive_in  = tactive_ff;
      tcount_in   = tcount_ff;

      result              = '0;
      result.sender_id    = sender_ff;
      result.receiver_id  = receiver_ff;
      result.frame_length = length_ff;

      if (opcode == OP_TICK) begin
         if (tactive_ff) begin
            tcount_in = tcount_inc;
            if (tcount_inc >= timeout_ticks) begin
               tactive_in = 1'b0;
               phase_in   = PH_IDLE;
               if (phase_ff == PH_HEAD || phase_ff == PH_DATA || phase_ff == PH_CSUM) begin
                  result.valid     = 1'b1;
                  result.event_res = EV_ABORT;
                  result.last      = 1'b1;
               end
            end
         end
      end else begin
         case (phase_ff)
            PH_SYNC2: begin
               if (rx_byte == SYNC_BYTE) begin
                  phase_in    = PH_HEAD;
                  hcount_in   = 2'd0;
                  sender_in   = '0;
                  receiver_in = '0;
                  length_in   = '0;
                  sum_in      = '0;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_HEAD: begin
               sum_in = sum_next;
               case (hcount_ff)
                  2'd0:    sender_in   = rx_byte;
                  2'd1:    receiver_in = rx_byte;
                  default: length_in   = len_hdr;
               endcase
               if (hcount_ff == 2'd3) begin
                  hcount_in = 2'd0;
                  if (len_hdr == 16'd0) begin
                     phase_in = PH_IDLE;
                  end else begin
                     pcount_in = '0;
                     phase_in  = PH_DATA;
                  end
               end else begin
                  hcount_in = 2'(hcount_ff + 2'd1);
               end
            end
            PH_DATA: begin
               sum_in              = sum_next;
               pcount_in           = pcount_inc;
               result.valid        = 1'b1;
               result.event_res    = EV_PAYLOAD;
               result.payload_byte = rx_byte;
               result.byte_index   = pcount_ff;
               if (pcount_inc >= length_ff) begin
                  phase_in = PH_CSUM;
               end
            end
            PH_CSUM: begin
               tactive_in       = 1'b0;
               phase_in         = PH_IDLE;
               result.valid     = 1'b1;
               result.event_res = (sum_ff == rx_byte) ? EV_GOOD : EV_BAD;
               result.last      = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
               if (rx_byte == SYNC_BYTE) begin
                  phase_in   = PH_SYNC2;
                  tactive_in = 1'b1;
                  tcount_in  = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         hcount_ff   <= '0;
         sender_ff   <= '0;
         receiver_ff <= '0;
         length_ff   <= '0;
         pcount_ff   <= '0;
         sum_ff      <= '0;
         tactive_ff  <= 1'b0;
         tcount_ff   <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         hcount_ff   <= hcount_in;
         sender_ff   <= sender_in;
         receiver_ff <= receiver_in;
         length_ff   <= length_in;
         pcount_ff   <= pcount_in;
         sum_ff      <= sum_in;
         tactive_ff  <= tactive_in;
         tcount_ff   <= tcount_in;
      end
   end

endmodule

// ===== src/sfr_out_stage.sv =====
// ----------------------------------------------------------------------------
// sfr_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfr_out_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  sfr_pkg::rsp_item_type              result,
   output logic                               slot_free,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sfr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast
);
   import sfr_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff,  item_in;

   assign slot_free = ~valid_ff | rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = result.valid;
         item_in  = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = item_ff.event_res;
   assign rsp_tlast  = item_ff.last;
   assign rsp_tdata  = {item_ff.frame_length, item_ff.byte_index, item_ff.payload_byte,
                        item_ff.receiver_id, item_ff.sender_id};

endmodule

// ===== src/serial_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver_core
// Parses sync/header/payload/checksum frames from a byte and tick stream.
//
//   channel  dir  handshake            payload
//   req      in   tvalid/tready        tuser opcode, tdata rx_byte
//   rsp      out  tvalid/tready/tlast  tuser event_res, tdata header/payload
//   csr      in   psel/penable/pready  timeout_ticks at address 0
//
// One transaction per cycle unless rsp stalls; input and result are both
// registered. The input register feeds the parser, whose combinational
// update holds the checksum add and compare. Reset is synchronous and
// clears all control state; the timeout returns to 100 ticks. A stalled rsp
// holds one result while one more transaction waits in the input register.
// ----------------------------------------------------------------------------
module serial_frame_receiver_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sfr_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] rx_byte
   input  logic                             req_tuser,  // [0] opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] sender_id, [15:8] receiver_id, [23:16] payload_byte,
   // [39:24] byte_index, [55:40] frame_length
   output logic [sfr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [1:0]                       rsp_tuser,  // [1:0] event_res
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sfr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import sfr_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic         opcode_ff,   opcode_in;
   logic [7:0]   byte_ff,     byte_in;
   logic [15:0]  timeout_ticks;
   logic         slot_free;
   logic         step;
   rsp_item_type result;

   assign step       = in_valid_ff & slot_free;
   assign req_tready = ~in_valid_ff | step;

   always_comb begin
      in_valid_in = in_valid_ff;
      opcode_in   = opcode_ff;
      byte_in     = byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         opcode_in   = req_tuser;
         byte_in     = req_tdata;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff <= opcode_in;
      byte_ff   <= byte_in;
   end

   sfr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .timeout_ticks (timeout_ticks)
   );

   sfr_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .opcode        (opcode_ff),
      .rx_byte       (byte_ff),
      .timeout_ticks (timeout_ticks),
      .result        (result)
   );

   sfr_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_last_matches_event: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != EV_PAYLOAD)))
      else $error("tlast does not match event kind");

   a_index_in_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == EV_PAYLOAD) |-> (rsp_tdata[39:24] < rsp_tdata[55:40]))
      else $error("payload index outside frame length");

   a_input_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !slot_free) |=> (in_valid_ff && $stable(byte_ff) && $stable(opcode_ff)))
      else $error("pending transaction lost while result stalled");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      slot_free |-> req_tready)
      else $error("input stalled with a free result slot");

   a_end_has_no_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[39:16] == '0))
      else $error("end result carries payload fields");

endmodule

// ===== tb/serial_frame_receiver_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_checker
// Passive checker for the serial frame receiver. Tracks the timeout register
// from CSR transactions, runs its own frame parser on every accepted request
// transaction and queues the frame events it predicts. Each accepted response
// transaction is compared with the oldest queued event. Mismatches, stray
// responses and bad register reads are counted and handed to the testbench.
// ----------------------------------------------------------------------------
module serial_frame_receiver_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [sfr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [sfr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]                     rsp_tuser,
   input  logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sfr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sfr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [sfr_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             fail_count,
   output int                             pending
);
   import sfr_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] TIMEOUT_ADDR = {CSR_TIMEOUT, 2'b00};
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      evt_type     ev;
      logic [7:0]  sender;
      logic [7:0]  receiver;
      logic [7:0]  data;
      logic [15:0] index;
      logic [15:0] length;
      logic        last;
   } frame_event_type;

   frame_event_type due_events[$];

   logic [15:0] timeout_ticks;
   phase_type   parse_phase;
   logic [1:0]  header_pos;
   logic [7:0]  sender_id;
   logic [7:0]  receiver_id;
   logic [15:0] frame_len;
   logic [15:0] payload_pos;
   logic [7:0]  byte_sum;
   logic        timer_on;
   logic [15:0] tick_count;
   int          mismatches = 0;

   task automatic clear_parser();
      timeout_ticks = TIMEOUT_RESET;
      parse_phase   = PH_IDLE;
      header_pos    = '0;
      sender_id     = '0;
      receiver_id   = '0;
      frame_len     = '0;
      payload_pos   = '0;
      byte_sum      = '0;
      timer_on      = 1'b0;
      tick_count    = '0;
      due_events.delete();
   endtask

   task automatic queue_event(input evt_type ev, input logic [7:0] data,
                              input logic [15:0] index, input logic last);
      frame_event_type item;
      item.ev       = ev;
      item.sender   = sender_id;
      item.receiver = receiver_id;
      item.data     = data;
      item.index    = index;
      item.length   = frame_len;
      item.last     = last;
      due_events.push_back(item);
   endtask

   task automatic parse_transaction(input opcode_type op, input logic [7:0] b);
      logic        busy;
      logic [15:0] index;
      if (op == OP_TICK) begin
         if (!timer_on) return;
         if (tick_count != TIMER_MAX) tick_count = tick_count + 16'd1;
         if (tick_count < timeout_ticks) return;
         timer_on = 1'b0;
         busy = parse_phase inside {PH_HEAD, PH_DATA, PH_CSUM};
         parse_phase = PH_IDLE;
         if (busy) queue_event(EV_ABORT, 8'h00, 16'h0000, 1'b1);
         return;
      end
      case (parse_phase)
         PH_SYNC2: begin
            if (b == SYNC_BYTE) begin
               parse_phase = PH_HEAD;
               header_pos  = '0;
               sender_id   = '0;
               receiver_id = '0;
               frame_len   = '0;
               byte_sum    = '0;
            end else begin
               parse_phase = PH_IDLE;
            end
         end
         PH_HEAD: begin
            byte_sum = 8'((9'(byte_sum) + 9'(b)) % SUM_MOD);
            case (header_pos)
               2'd0: sender_id = b;
               2'd1: receiver_id = b;
               2'd2: frame_len = {b, 8'h00};
               default: frame_len[7:0] = b;
            endcase
            if (header_pos == 2'd3) begin
               header_pos = '0;
               if (frame_len == 16'h0000) begin
                  parse_phase = PH_IDLE;
               end else begin
                  payload_pos = '0;
                  parse_phase = PH_DATA;
               end
            end else begin
               header_pos = header_pos + 2'd1;
            end
         end
         PH_DATA: begin
            index = payload_pos;
            byte_sum = 8'((9'(byte_sum) + 9'(b)) % SUM_MOD);
            queue_event(EV_PAYLOAD, b, index, 1'b0);
            payload_pos = index + 16'd1;
            if (payload_pos >= frame_len) parse_phase = PH_CSUM;
         end
         PH_CSUM: begin
            timer_on = 1'b0;
            parse_phase = PH_IDLE;
            queue_event((byte_sum == b) ? EV_GOOD : EV_BAD, 8'h00, 16'h0000, 1'b1);
         end
         default: begin
            parse_phase = PH_IDLE;
            if (b == SYNC_BYTE) begin
               parse_phase = PH_SYNC2;
               timer_on    = 1'b1;
               tick_count  = '0;
            end
         end
      endcase
   endtask

   task automatic check_response();
      frame_event_type seen;
      frame_event_type want;
      seen.ev       = evt_type'(rsp_tuser);
      seen.sender   = rsp_tdata[7:0];
      seen.receiver = rsp_tdata[15:8];
      seen.data     = rsp_tdata[23:16];
      seen.index    = rsp_tdata[39:24];
      seen.length   = rsp_tdata[55:40];
      seen.last     = rsp_tlast;
      if (due_events.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: stray response: ev=%0d src=%h dst=%h byte=%h idx=%0d len=%0d last=%b",
                     $realtime, seen.ev, seen.sender, seen.receiver, seen.data,
                     seen.index, seen.length, seen.last);
         return;
      end
      want = due_events.pop_front();
      if (seen !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%0t: response mismatch", $realtime);
            $display("   expected ev=%0d src=%h dst=%h byte=%h idx=%0d len=%0d last=%b",
                     want.ev, want.sender, want.receiver, want.data,
                     want.index, want.length, want.last);
            $display("   actual   ev=%0d src=%h dst=%h byte=%h idx=%0d len=%0d last=%b",
                     seen.ev, seen.sender, seen.receiver, seen.data,
                     seen.index, seen.length, seen.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         if (csr_psel && csr_penable && csr_pready && csr_paddr == TIMEOUT_ADDR) begin
            if (csr_pwrite) begin
               timeout_ticks = csr_pwdata[15:0];
            end else if (csr_prdata[15:0] !== timeout_ticks) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: timeout readback mismatch: expected %0d actual %0d",
                           $realtime, timeout_ticks, csr_prdata[15:0]);
            end
         end
         if (req_tvalid && req_tready) parse_transaction(opcode_type'(req_tuser), req_tdata);
      end
      pending    <= due_events.size();
      fail_count <= mismatches;
   end

endmodule

// ===== tb/serial_frame_receiver_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_core_test
// Stimulus and verdict for the serial frame receiver. A short directed run
// covers sync errors, zero length frames, good and bad checksums and timeout
// aborts; random frames, truncated frames, noise and tick bursts follow under
// several timeout settings. Both stream sides idle at random. Checking is done
// by the checker instance beside the block.
// ----------------------------------------------------------------------------
module serial_frame_receiver_core_test;
   import sfr_pkg::*;

   localparam time CLOCK_PERIOD      = 8ns;
   localparam int  RESET_CYCLES      = 6;
   localparam int  SETTLE_CYCLES     = 6;
   localparam int  ITEMS_PER_SETTING = 200;
   localparam int  SETTING_COUNT     = 7;
   localparam int  CYCLE_LIMIT       = 500000;
   localparam int  REG_STRIDE        = 4;

   localparam logic [CSR_ADDR_W-1:0] TIMEOUT_ADDR = {CSR_TIMEOUT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR =
      CSR_ADDR_W'(REG_STRIDE * (int'(CSR_TIMEOUT) + 1));

   typedef logic [7:0] byte_seq_type[$];

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = OP_BYTE;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          fail_count;
   int          pending;
   int          cycle_count = 0;
   int          bytes_sent  = 0;
   bit          quiet       = 1'b0;
   logic [15:0] timeout_now = TIMEOUT_RESET;

   serial_frame_receiver_core dut (.*);

   serial_frame_receiver_checker checker_inst (.*);

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // stall the response side for a random number of cycles per transaction
   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_item(input opcode_type op, input logic [7:0] b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_BYTE) bytes_sent++;
   endtask

   task automatic send_bytes(input byte_seq_type seq);
      foreach (seq[i]) send_item(OP_BYTE, seq[i]);
   endtask

   task automatic maybe_tick();
      if ($urandom_range(0, 11) == 0) send_item(OP_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_timeout(input logic [15:0] ticks);
      csr_access(1'b1, SPARE_ADDR, $urandom);
      csr_access(1'b1, TIMEOUT_ADDR, {16'($urandom_range(0, 65535)), ticks});
      csr_access(1'b0, TIMEOUT_ADDR, '0);
      timeout_now = ticks;
   endtask

   // send sync, header and body bytes; close with a checksum once a non-empty body is full
   task automatic send_frame(input logic [15:0] len, input int body, input bit intact);
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] header[4];
      sum = 8'h00;
      header[0] = 8'($urandom_range(0, 255));
      header[1] = 8'($urandom_range(0, 255));
      header[2] = len[15:8];
      header[3] = len[7:0];
      send_item(OP_BYTE, SYNC_BYTE);
      send_item(OP_BYTE, SYNC_BYTE);
      foreach (header[i]) begin
         sum = 8'((9'(sum) + 9'(header[i])) % SUM_MOD);
         send_item(OP_BYTE, header[i]);
         maybe_tick();
      end
      for (int k = 0; k < body; k++) begin
         b = 8'($urandom_range(0, 255));
         sum = 8'((9'(sum) + 9'(b)) % SUM_MOD);
         send_item(OP_BYTE, b);
         maybe_tick();
      end
      if (len != 16'h0000 && body == int'(len))
         send_item(OP_BYTE, intact ? sum : 8'($urandom_range(0, 255)));
   endtask

   task automatic send_burst();
      int kind;
      int len;
      int body;
      int n;
      quiet = ($urandom_range(0, 5) == 0);
      kind  = $urandom_range(0, 99);
      if (kind < 60) begin
         n = $urandom_range(0, 99);
         if (n < 8) len = 0;
         else if (n < 95) len = $urandom_range(1, 12);
         else len = $urandom_range(200, 300);
         send_frame(16'(len), len, $urandom_range(0, 3) != 0);
      end else if (kind < 75) begin
         len  = (timeout_now <= 64) ? $urandom_range(0, 65535) : $urandom_range(1, 20);
         body = $urandom_range(0, 6);
         if (body >= len) body = (len == 0) ? 0 : len - 1;
         send_frame(16'(len), body, 1'b1);
         n = (timeout_now <= 64) ? int'(timeout_now) + 1 : $urandom_range(0, 5);
         repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end else if (kind < 90) begin
         n = $urandom_range(1, 6);
         repeat (n)
            send_item(($urandom_range(0, 3) == 0) ? OP_TICK : OP_BYTE,
                      ($urandom_range(0, 2) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 255)));
      end else begin
         n = (timeout_now <= 64) ? $urandom_range(0, int'(timeout_now) + 1)
                                 : $urandom_range(1, 10);
         repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      byte_seq_type seq;
      logic [15:0]  plan[SETTING_COUNT];
      int           start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, TIMEOUT_ADDR, '0);

      send_item(OP_TICK, 8'h00);
      seq = '{SYNC_BYTE, 8'h12, SYNC_BYTE, SYNC_BYTE, 8'h01, 8'h02, 8'h00, 8'h00};
      send_bytes(seq);
      seq = '{SYNC_BYTE, SYNC_BYTE, 8'h00, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h02};
      send_bytes(seq);
      seq = '{SYNC_BYTE, SYNC_BYTE, 8'hAA, 8'h55, 8'h00, 8'h01, 8'h7E, 8'hFF};
      send_bytes(seq);
      drain();
      program_timeout(16'h0000);
      seq = '{SYNC_BYTE, SYNC_BYTE, 8'h01};
      send_bytes(seq);
      send_item(OP_TICK, 8'hFF);
      send_item(OP_TICK, 8'h00);

      plan[0] = TIMER_MAX;
      plan[1] = 16'd1;
      plan[2] = 16'($urandom_range(2, 30));
      plan[3] = 16'($urandom_range(31, 300));
      plan[4] = 16'h0000;
      plan[5] = 16'($urandom_range(2, 12));
      plan[6] = TIMEOUT_RESET;
      foreach (plan[i]) begin
         drain();
         program_timeout(plan[i]);
         start = bytes_sent;
         while (bytes_sent - start < ITEMS_PER_SETTING) send_burst();
      end

      quiet = 1'b0;
      drain();
      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
